// ----- src/dhcp_offer_parser_core_macros.svh -----
// Assertion macros shared by the DHCP offer parser modules.
`ifndef DHCP_OFFER_PARSER_CORE_MACROS_SVH
`define DHCP_OFFER_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define DOP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define DOP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DOP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define DOP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/dop_pkg.sv -----
// Types and constants shared by the DHCP offer parser modules.
`default_nettype none
package dop_pkg;
   localparam int OFFSET_W = 11;

   localparam logic [OFFSET_W-1:0] OPT_START    = 11'd240;
   localparam logic [31:0]         COOKIE_VALUE = 32'h63825363;
   localparam logic [7:0]          OPT_END_CODE = 8'd255;
   localparam logic [7:0]          OPT_PAD_CODE = 8'd0;
   localparam logic [7:0]          OPT_SUBNET   = 8'd1;
   localparam logic [7:0]          OPT_ROUTER   = 8'd3;
   localparam logic [7:0]          OP_REPLY     = 8'd2;

   localparam logic [1:0] REASON_OK         = 2'd0;
   localparam logic [1:0] REASON_TOO_SHORT  = 2'd1;
   localparam logic [1:0] REASON_NOT_REPLY  = 2'd2;
   localparam logic [1:0] REASON_BAD_COOKIE = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Where in the message a byte sits.
   typedef struct packed {
      logic is_op;
      logic is_addr;
      logic is_cookie;
      logic is_opt;
   } dop_class_type;

   // One classified byte as it travels from the front end to the parser.
   typedef struct packed {
      logic [7:0]          data_byte;
      logic                last_byte;
      dop_class_type       cls;
      logic [OFFSET_W-1:0] length;
   } dop_entry_type;
endpackage
`default_nettype wire

// ----- src/dop_ifs.sv -----
// Handshake channel interfaces of the DHCP offer parser.
`default_nettype none
interface dop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source(output valid, data_byte, last_byte, input ready);
   modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface dop_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [1:0]  reject_reason;
   logic [31:0] offered_ip;
   logic [31:0] subnet_mask;
   logic        subnet_valid;
   logic [31:0] router_addr;
   logic        router_valid;
   modport source(output valid, accepted, reject_reason, offered_ip, subnet_mask,
                  subnet_valid, router_addr, router_valid, input ready);
   modport sink(input valid, accepted, reject_reason, offered_ip, subnet_mask,
                subnet_valid, router_addr, router_valid, output ready);
endinterface

interface dop_csr_if;
   logic        valid;
   logic        ready;
   logic [10:0] wdata;
   modport source(output valid, wdata, input ready);
   modport sink(input valid, wdata, output ready);
endinterface
`default_nettype wire

// ----- src/dop_front.sv -----
// Front end: counts byte offsets and classifies each accepted byte.
`default_nettype none
module dop_front #(
   parameter int OPTION_AREA_BYTES = 312,
   parameter int MAX_FRAME_BYTES   = 1500
) (
   input  wire logic           clock,
   input  wire logic           reset,
   dop_req_if.sink             req,
   output dop_pkg::dop_entry_type push_entry,
   output logic                push_valid,
   input  wire logic           push_ready
);
   localparam logic [dop_pkg::OFFSET_W-1:0] MAX_LEN =
      dop_pkg::OFFSET_W'(MAX_FRAME_BYTES);
   localparam logic [dop_pkg::OFFSET_W-1:0] OPT_LIMIT =
      dop_pkg::OFFSET_W'(240 + OPTION_AREA_BYTES);

   logic [dop_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic                         counted;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign counted    = offset_ff < MAX_LEN;

   always_comb begin
      push_entry.data_byte     = req.data_byte;
      push_entry.last_byte     = req.last_byte;
      push_entry.cls.is_op     = counted && (offset_ff == '0);
      push_entry.cls.is_addr   = counted && (offset_ff >= 11'd16) && (offset_ff <= 11'd19);
      push_entry.cls.is_cookie = counted && (offset_ff >= 11'd236) && (offset_ff <= 11'd239);
      push_entry.cls.is_opt    = counted && (offset_ff >= dop_pkg::OPT_START) &&
                                 (offset_ff < OPT_LIMIT);
      // Offset saturates at the largest frame; this is the length so far.
      push_entry.length        = counted ? offset_ff + 11'd1 : offset_ff;
   end

   always_comb begin
      offset_in = offset_ff;
      if (req.valid && push_ready) begin
         offset_in = req.last_byte ? '0 : push_entry.length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/dop_queue.sv -----
// Short queue of classified bytes between the front end and the parser.
`default_nettype none
`include "dhcp_offer_parser_core_macros.svh"
module dop_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dop_pkg::dop_entry_type push_entry,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   output dop_pkg::dop_entry_type      pop_entry,
   output logic                        pop_valid,
   input  wire logic                   pop_ready
);
   dop_pkg::dop_entry_type slot_ff [dop_pkg::QUEUE_DEPTH];
   logic [dop_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [dop_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != dop_pkg::QUEUE_CNT_W'(dop_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `DOP_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= dop_pkg::QUEUE_CNT_W'(dop_pkg::QUEUE_DEPTH), "queue count overflow")
   `DOP_ASSERT_IMP(a_ptr_track, clock, reset, 1'b1,
      (wr_ptr_ff - rd_ptr_ff) == count_ff[dop_pkg::QUEUE_PTR_W-1:0],
      "queue pointers disagree with count")
   `DOP_ASSERT_IMP(a_empty_no_pop, clock, reset, count_ff == '0, !pop,
      "pop from an empty queue")
endmodule
`default_nettype wire

// ----- src/dop_back.sv -----
// Parser back end: walks header and options and registers the frame verdict.
`default_nettype none
`include "dhcp_offer_parser_core_macros.svh"
module dop_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dop_pkg::dop_entry_type pop_entry,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire logic [10:0]            min_len,
   dop_rsp_if.source                   rsp
);
   localparam logic [1:0] PH_TYPE  = 2'd0;
   localparam logic [1:0] PH_LEN   = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;

   logic        reply_ff, reply_in;
   logic [31:0] cookie_ff, cookie_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] gw_ff, gw_in;
   logic        mask_seen_ff, mask_seen_in;
   logic        gw_seen_ff, gw_seen_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  remain_ff, remain_in;
   logic [2:0]  cap_ff, cap_in;
   logic        ended_ff, ended_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        accepted_ff, accepted_in;
   logic [1:0]  reason_ff, reason_in;
   logic [31:0] ip_out_ff, ip_out_in;
   logic [31:0] mask_out_ff, mask_out_in;
   logic        mask_vld_ff, mask_vld_in;
   logic [31:0] gw_out_ff, gw_out_in;
   logic        gw_vld_ff, gw_vld_in;

   logic        pop;
   logic [7:0]  b;
   logic [2:0]  cap_next;
   logic [7:0]  remain_next;
   logic [1:0]  reason;

   // A final byte waits until the result register is free or being drained.
   assign pop_ready = !pop_entry.last_byte || !rsp_valid_ff || rsp.ready;
   assign pop       = pop_valid && pop_ready;
   assign b         = pop_entry.data_byte;
   assign cap_next  = cap_ff + 3'd1;
   assign remain_next = remain_ff - 8'd1;

   always_comb begin
      reply_in     = reply_ff;
      cookie_in    = cookie_ff;
      addr_in      = addr_ff;
      mask_in      = mask_ff;
      gw_in        = gw_ff;
      mask_seen_in = mask_seen_ff;
      gw_seen_in   = gw_seen_ff;
      phase_in     = phase_ff;
      code_in      = code_ff;
      remain_in    = remain_ff;
      cap_in       = cap_ff;
      ended_in     = ended_ff;
      if (pop) begin
         if (pop_entry.cls.is_op) begin
            reply_in = b == dop_pkg::OP_REPLY;
         end
         if (pop_entry.cls.is_addr) begin
            addr_in = {addr_ff[23:0], b};
         end
         if (pop_entry.cls.is_cookie) begin
            cookie_in = {cookie_ff[23:0], b};
         end
         if (pop_entry.cls.is_opt && !ended_ff) begin
            case (phase_ff)
               PH_TYPE: begin
                  if (b == dop_pkg::OPT_END_CODE) begin
                     ended_in = 1'b1;
                  end else if (b != dop_pkg::OPT_PAD_CODE) begin
                     code_in  = b;
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  remain_in = b;
                  cap_in    = '0;
                  if (code_ff == dop_pkg::OPT_SUBNET) mask_seen_in = 1'b0;
                  if (code_ff == dop_pkg::OPT_ROUTER) gw_seen_in = 1'b0;
                  phase_in  = (b == 8'd0) ? PH_TYPE : PH_VALUE;
               end
               PH_VALUE: begin
                  if ((code_ff == dop_pkg::OPT_SUBNET || code_ff == dop_pkg::OPT_ROUTER) &&
                      cap_ff < 3'd4) begin
                     if (code_ff == dop_pkg::OPT_SUBNET) begin
                        mask_in = {mask_ff[23:0], b};
                        if (cap_next == 3'd4) mask_seen_in = 1'b1;
                     end else begin
                        gw_in = {gw_ff[23:0], b};
                        if (cap_next == 3'd4) gw_seen_in = 1'b1;
                     end
                     cap_in = cap_next;
                  end
                  remain_in = remain_next;
                  if (remain_next == 8'd0) phase_in = PH_TYPE;
               end
               default: begin
                  phase_in = PH_TYPE;
               end
            endcase
         end
      end
   end

   // Verdict from the state as updated by the final byte.
   always_comb begin
      if (pop_entry.length < min_len) begin
         reason = dop_pkg::REASON_TOO_SHORT;
      end else if (!reply_in) begin
         reason = dop_pkg::REASON_NOT_REPLY;
      end else if (pop_entry.length < dop_pkg::OPT_START ||
                   cookie_in != dop_pkg::COOKIE_VALUE) begin
         reason = dop_pkg::REASON_BAD_COOKIE;
      end else begin
         reason = dop_pkg::REASON_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      accepted_in  = accepted_ff;
      reason_in    = reason_ff;
      ip_out_in    = ip_out_ff;
      mask_out_in  = mask_out_ff;
      mask_vld_in  = mask_vld_ff;
      gw_out_in    = gw_out_ff;
      gw_vld_in    = gw_vld_ff;
      if (pop && pop_entry.last_byte) begin
         rsp_valid_in = 1'b1;
         accepted_in  = reason == dop_pkg::REASON_OK;
         reason_in    = reason;
         if (reason == dop_pkg::REASON_OK) begin
            ip_out_in   = addr_in;
            mask_out_in = mask_seen_in ? mask_in : '0;
            mask_vld_in = mask_seen_in;
            gw_out_in   = gw_seen_in ? gw_in : '0;
            gw_vld_in   = gw_seen_in;
         end else begin
            ip_out_in   = '0;
            mask_out_in = '0;
            mask_vld_in = 1'b0;
            gw_out_in   = '0;
            gw_vld_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (pop && pop_entry.last_byte)) begin
         reply_ff     <= 1'b0;
         cookie_ff    <= '0;
         addr_ff      <= '0;
         mask_ff      <= '0;
         gw_ff        <= '0;
         mask_seen_ff <= 1'b0;
         gw_seen_ff   <= 1'b0;
         phase_ff     <= PH_TYPE;
         code_ff      <= '0;
         remain_ff    <= '0;
         cap_ff       <= '0;
         ended_ff     <= 1'b0;
      end else begin
         reply_ff     <= reply_in;
         cookie_ff    <= cookie_in;
         addr_ff      <= addr_in;
         mask_ff      <= mask_in;
         gw_ff        <= gw_in;
         mask_seen_ff <= mask_seen_in;
         gw_seen_ff   <= gw_seen_in;
         phase_ff     <= phase_in;
         code_ff      <= code_in;
         remain_ff    <= remain_in;
         cap_ff       <= cap_in;
         ended_ff     <= ended_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      accepted_ff <= accepted_in;
      reason_ff   <= reason_in;
      ip_out_ff   <= ip_out_in;
      mask_out_ff <= mask_out_in;
      mask_vld_ff <= mask_vld_in;
      gw_out_ff   <= gw_out_in;
      gw_vld_ff   <= gw_vld_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.accepted      = accepted_ff;
   assign rsp.reject_reason = reason_ff;
   assign rsp.offered_ip    = ip_out_ff;
   assign rsp.subnet_mask   = mask_out_ff;
   assign rsp.subnet_valid  = mask_vld_ff;
   assign rsp.router_addr   = gw_out_ff;
   assign rsp.router_valid  = gw_vld_ff;

   `DOP_ASSERT_IMP(a_verdict, clock, reset, rsp_valid_ff,
      accepted_ff == (reason_ff == dop_pkg::REASON_OK), "verdict and reason disagree")
   `DOP_ASSERT_IMP(a_reject_zero, clock, reset, rsp_valid_ff && !accepted_ff,
      ip_out_ff == '0 && !mask_vld_ff && !gw_vld_ff, "rejected item carries data")
   `DOP_ASSERT_NXT(a_last_clears, clock, reset, pop && pop_entry.last_byte,
      cap_ff == '0 && !ended_ff && phase_ff == PH_TYPE, "frame state not cleared")
endmodule
`default_nettype wire

// ----- src/dhcp_offer_parser_core.sv -----
// Top level of the DHCP offer parser: front end, byte queue, parser and length register.
// Throughput: one message byte per cycle, sustained while results are taken.
// The final byte is written into the byte queue; the verdict formed when it leaves the queue
// is held in the result register, from which the result item is taken.
// A held result stalls the parser only at the next final byte; four bytes then fill the queue.
// Reset is synchronous and active high; it clears all frame state and sets the minimum length to 552.
`default_nettype none
module dhcp_offer_parser_core #(
   parameter int OPTION_AREA_BYTES = 312,
   parameter int MAX_FRAME_BYTES   = 1500
) (
   input wire logic clock,
   input wire logic reset,
   dop_req_if.sink   req,
   dop_rsp_if.source rsp,
   dop_csr_if.sink   csr
);
   // The minimum frame length register. The user must see that it is written only between frames,
   // so the parser compares against it directly; the block itself leaves this unenforced.
   logic [10:0] min_len_ff, min_len_in;

   // Classified bytes flow from the front end through the queue.
   dop_pkg::dop_entry_type push_entry, pop_entry;
   logic push_valid, push_ready, pop_valid, pop_ready;

   assign csr.ready  = 1'b1;
   assign min_len_in = csr.valid ? csr.wdata : min_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= 11'd552;
      end else begin
         min_len_ff <= min_len_in;
      end
   end

   // The front end tracks the byte offset, which saturates at the largest
   // frame, and tags each byte with the header field or option area it hits.
   dop_front #(
      .OPTION_AREA_BYTES(OPTION_AREA_BYTES),
      .MAX_FRAME_BYTES  (MAX_FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .push_entry(push_entry),
      .push_valid(push_valid),
      .push_ready(push_ready)
   );

   // The queue lets the front end keep taking bytes while a result is held.
   dop_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_entry(push_entry),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .pop_entry (pop_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready)
   );

   // The parser walks the option records and registers one result per frame.
   dop_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_entry(pop_entry),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .min_len  (min_len_ff),
      .rsp      (rsp)
   );
endmodule
`default_nettype wire

// ----- dv/dhcp_offer_checker.sv -----
`timescale 1ns / 100ps
// Offer checker: follows accepted bytes and register writes, predicts each result item, compares.
module dhcp_offer_checker #(
   parameter int OPTION_AREA_BYTES = 312,
   parameter int MAX_FRAME_BYTES   = 1500
) (
   input  wire logic clock,
   input  wire logic reset,
   dop_req_if        req_tap,
   dop_rsp_if        rsp_tap,
   dop_csr_if        csr_tap,
   output int        fail_count,
   output int        pending,
   output int        accepted_count
);

   typedef enum logic [1:0] {WALK_TYPE, WALK_LEN, WALK_VALUE} walk_type;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  reason;
      logic [31:0] offered_ip;
      logic [31:0] subnet_mask;
      logic        subnet_valid;
      logic [31:0] router_addr;
      logic        router_valid;
   } offer_type;

   offer_type   expected_offers[$];
   logic [10:0] min_length;
   int          frame_len;
   logic        saw_reply;
   logic [31:0] cookie_bytes;
   logic [31:0] addr_bytes;
   logic [31:0] mask_bytes;
   logic [31:0] gw_bytes;
   logic        mask_done;
   logic        gw_done;
   walk_type    walk;
   logic [7:0]  opt_code;
   logic [7:0]  opt_left;
   int          grabbed;
   logic        opts_done;
   int          mismatches = 0;
   int          accepts = 0;

   assign fail_count     = mismatches;
   assign accepted_count = accepts;

   function automatic void clear_frame();
      frame_len    = 0;
      saw_reply    = 1'b0;
      cookie_bytes = '0;
      addr_bytes   = '0;
      mask_bytes   = '0;
      gw_bytes     = '0;
      mask_done    = 1'b0;
      gw_done      = 1'b0;
      walk         = WALK_TYPE;
      opt_code     = '0;
      opt_left     = '0;
      grabbed      = 0;
      opts_done    = 1'b0;
   endfunction

   // One byte of the option area, walked as type, length and value.
   function automatic void walk_option(logic [7:0] b);
      if (!opts_done) begin
         case (walk)
            WALK_TYPE: begin
               if (b == dop_pkg::OPT_END_CODE) begin
                  opts_done = 1'b1;
               end else if (b != dop_pkg::OPT_PAD_CODE) begin
                  opt_code = b;
                  walk     = WALK_LEN;
               end
            end
            WALK_LEN: begin
               opt_left = b;
               grabbed  = 0;
               if (opt_code == dop_pkg::OPT_SUBNET) mask_done = 1'b0;
               if (opt_code == dop_pkg::OPT_ROUTER) gw_done = 1'b0;
               walk = (b == 8'd0) ? WALK_TYPE : WALK_VALUE;
            end
            default: begin
               if ((opt_code == dop_pkg::OPT_SUBNET || opt_code == dop_pkg::OPT_ROUTER) &&
                   grabbed < 4) begin
                  if (opt_code == dop_pkg::OPT_SUBNET) mask_bytes = {mask_bytes[23:0], b};
                  else gw_bytes = {gw_bytes[23:0], b};
                  grabbed++;
                  if (grabbed == 4) begin
                     if (opt_code == dop_pkg::OPT_SUBNET) mask_done = 1'b1;
                     else gw_done = 1'b1;
                  end
               end
               opt_left = opt_left - 8'd1;
               if (opt_left == 8'd0) walk = WALK_TYPE;
            end
         endcase
      end
   endfunction

   function automatic void take_byte(logic [7:0] b, logic last);
      offer_type r;
      if (frame_len < MAX_FRAME_BYTES) begin
         if (frame_len == 0) saw_reply = (b == dop_pkg::OP_REPLY);
         if (frame_len >= 16 && frame_len <= 19) addr_bytes = {addr_bytes[23:0], b};
         if (frame_len >= 236 && frame_len <= 239) cookie_bytes = {cookie_bytes[23:0], b};
         if (frame_len >= int'(dop_pkg::OPT_START) &&
             frame_len < int'(dop_pkg::OPT_START) + OPTION_AREA_BYTES)
            walk_option(b);
         frame_len++;
      end
      if (last) begin
         r = '0;
         if (frame_len < int'(min_length)) begin
            r.reason = dop_pkg::REASON_TOO_SHORT;
         end else if (!saw_reply) begin
            r.reason = dop_pkg::REASON_NOT_REPLY;
         end else if (frame_len < int'(dop_pkg::OPT_START) ||
                      cookie_bytes != dop_pkg::COOKIE_VALUE) begin
            r.reason = dop_pkg::REASON_BAD_COOKIE;
         end else begin
            r.accepted     = 1'b1;
            r.reason       = dop_pkg::REASON_OK;
            r.offered_ip   = addr_bytes;
            r.subnet_mask  = mask_done ? mask_bytes : '0;
            r.subnet_valid = mask_done;
            r.router_addr  = gw_done ? gw_bytes : '0;
            r.router_valid = gw_done;
         end
         expected_offers.push_back(r);
         clear_frame();
      end
   endfunction

   function automatic void field_check(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] %s: expected %0h, got %0h", $realtime, what, want, got);
      end
   endfunction

   function automatic void compare_offer(offer_type got);
      offer_type want;
      if (expected_offers.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] result item with none expected: %p", $realtime, got);
      end else begin
         want = expected_offers.pop_front();
         if (want.accepted) accepts++;
         field_check("accepted", 32'(want.accepted), 32'(got.accepted));
         field_check("reject_reason", 32'(want.reason), 32'(got.reason));
         field_check("offered_ip", want.offered_ip, got.offered_ip);
         field_check("subnet_mask", want.subnet_mask, got.subnet_mask);
         field_check("subnet_valid", 32'(want.subnet_valid), 32'(got.subnet_valid));
         field_check("router_addr", want.router_addr, got.router_addr);
         field_check("router_valid", 32'(want.router_valid), 32'(got.router_valid));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         min_length = 11'd552;
         clear_frame();
         expected_offers.delete();
      end else begin
         if (csr_tap.valid && csr_tap.ready) min_length = csr_tap.wdata;
         if (req_tap.valid && req_tap.ready) take_byte(req_tap.data_byte, req_tap.last_byte);
         if (rsp_tap.valid && rsp_tap.ready)
            compare_offer('{rsp_tap.accepted, rsp_tap.reject_reason, rsp_tap.offered_ip,
                            rsp_tap.subnet_mask, rsp_tap.subnet_valid, rsp_tap.router_addr,
                            rsp_tap.router_valid});
      end
      pending = expected_offers.size();
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the DHCP offer parser: clock, reset, frame stimulus, result stalls, verdict.
module tb;
   localparam int OPTION_AREA_BYTES = 312;
   localparam int MAX_FRAME_BYTES   = 1500;
   // The limit leaves wide margin over a correct run.
   localparam int LIMIT_CYCLES      = 20_000;
   // Length of the long result stall, long enough to fill the byte queue behind it.
   localparam int HOLD_CYCLES       = 64;

   logic clock;
   logic reset;

   dop_req_if req_ch();
   dop_rsp_if rsp_ch();
   dop_csr_if csr_ch();

   int fail_count;
   int pending;
   int accepted_count;

   // Shared stimulus controls. When gaps_on is low neither side idles, which gives
   // stretches of back-to-back traffic. hold_results asks the receiver for a long stall.
   logic gaps_on      = 1'b1;
   logic hold_results = 1'b0;

   logic [7:0] frame_q[$];
   int         frames_sent = 0;
   int         bytes_sent  = 0;
   int         cycle_count = 0;

   dhcp_offer_parser_core #(
      .OPTION_AREA_BYTES(OPTION_AREA_BYTES),
      .MAX_FRAME_BYTES  (MAX_FRAME_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   dhcp_offer_checker #(
      .OPTION_AREA_BYTES(OPTION_AREA_BYTES),
      .MAX_FRAME_BYTES  (MAX_FRAME_BYTES)
   ) offer_check (
      .clock         (clock),
      .reset         (reset),
      .req_tap       (req_ch),
      .rsp_tap       (rsp_ch),
      .csr_tap       (csr_ch),
      .fail_count    (fail_count),
      .pending       (pending),
      .accepted_count(accepted_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The watchdog counts cycles and ends a run that never drains.
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("Run timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending);
      $display("== FAIL ==");
      $finish;
   end

   // The result receiver. It changes ready only at falling edges. Normally it drops ready
   // at random, in 17 of 100 draws on average; on request it holds ready low for a long stretch that it
   // counts itself, so the parser backs up while the sender keeps offering bytes.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_results = 1'b0;
         end else begin
            rsp_ch.ready <= (!gaps_on || $urandom_range(0, 99) >= 17);
         end
      end
   end

   // Drive one byte and wait until the parser takes it. Entered and left at a falling edge;
   // valid stays high on return so that the next byte can follow without a gap.
   task automatic drive_byte(input logic [7:0] b, input logic last);
      if (gaps_on && $urandom_range(0, 99) < 20) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) drive_byte(frame_q[i], i == frame_q.size() - 1);
      frames_sent++;
      bytes_sent += frame_q.size();
   endtask

   // Stop offering bytes and wait until every predicted result item has been taken,
   // then let the clock run on before returning.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(negedge clock);
   endtask

   // Write the minimum frame length; only called once the parser is idle.
   task automatic write_min_length(input logic [10:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.wdata <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // The fixed header: random fields, op at offset 0, offered address at 16..19 and the
   // magic cookie at 236..239. A bad cookie has one bit flipped.
   function automatic void begin_offer(input logic reply, input logic cookie_ok);
      logic [7:0]  op;
      logic [31:0] magic;
      frame_q.delete();
      repeat (240) frame_q.push_back(8'($urandom));
      op = 8'($urandom);
      if (reply) op = dop_pkg::OP_REPLY;
      else if (op == dop_pkg::OP_REPLY) op = 8'h01;
      frame_q[0] = op;
      magic = dop_pkg::COOKIE_VALUE;
      if (!cookie_ok) magic ^= 32'h1 << $urandom_range(0, 31);
      for (int i = 0; i < 4; i++) frame_q[236 + i] = magic[31 - 8 * i -: 8];
   endfunction

   // One option record; value bytes past the first four are random.
   function automatic void add_option(input logic [7:0] code, input logic [7:0] len,
                                      input logic [31:0] value);
      frame_q.push_back(code);
      frame_q.push_back(len);
      for (int i = 0; i < len; i++)
         frame_q.push_back(i < 4 ? value[31 - 8 * i -: 8] : 8'($urandom));
   endfunction

   // Pad with zeros or random bytes, or cut, to an exact frame size.
   function automatic void fill_to(input int total, input logic zeros);
      while (frame_q.size() < total) frame_q.push_back(zeros ? 8'h00 : 8'($urandom));
      while (frame_q.size() > total) void'(frame_q.pop_back());
   endfunction

   // A short random frame of one to four bytes, half of them opening with the reply op.
   task automatic send_short_frame();
      frame_q.delete();
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
      if ($urandom_range(0, 1)) frame_q[0] = dop_pkg::OP_REPLY;
      send_frame();
   endtask

   initial begin
      int first_frame;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.last_byte = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.wdata     = 11'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (3) @(negedge clock);

      // Reset value of the minimum length is 552: a lone reply op and a cut header
      // are both too short.
      frame_q.delete();
      frame_q.push_back(dop_pkg::OP_REPLY);
      send_frame();
      begin_offer(1'b1, 1'b1);
      fill_to(5, 1'b0);
      send_frame();

      // Pad, a subnet value that is too short, a router option repeated with a longer
      // value (the later one wins), an empty unknown option, a good subnet, the end
      // option, and a subnet record after the end that must be ignored. Sent with no
      // idling on either side.
      drain_results();
      write_min_length(11'd240);
      gaps_on = 1'b0;
      begin_offer(1'b1, 1'b1);
      frame_q.push_back(dop_pkg::OPT_PAD_CODE);
      add_option(dop_pkg::OPT_SUBNET, 8'd2, 32'hAABB0000);
      add_option(dop_pkg::OPT_ROUTER, 8'd4, 32'h0A000001);
      add_option(dop_pkg::OPT_ROUTER, 8'd6, 32'h0A0000FE);
      add_option(8'd50, 8'd0, 32'h0);
      add_option(dop_pkg::OPT_SUBNET, 8'd4, 32'hFFFF0000);
      frame_q.push_back(dop_pkg::OPT_END_CODE);
      add_option(dop_pkg::OPT_SUBNET, 8'd4, 32'h12345678);
      send_frame();
      gaps_on = 1'b1;

      // A subnet value cut off by the end of the frame.
      begin_offer(1'b1, 1'b1);
      add_option(dop_pkg::OPT_ROUTER, 8'd4, $urandom);
      frame_q.push_back(dop_pkg::OPT_SUBNET);
      frame_q.push_back(8'd4);
      frame_q.push_back(8'hFF);
      frame_q.push_back(8'hFF);
      send_frame();

      // Short random frames at settings near zero, where they fail on length, op or
      // cookie. The second round opens with a long result stall while the sender keeps
      // pushing one-byte frames, so the queue fills and the input stalls. The third
      // round runs with no idling on either side.
      for (int phase = 0; phase < 3; phase++) begin
         drain_results();
         write_min_length(11'($urandom_range(0, 3)));
         gaps_on = (phase != 2);
         if (phase == 1) begin
            gaps_on      = 1'b0;
            hold_results = 1'b1;
            repeat (12) begin
               frame_q.delete();
               frame_q.push_back(8'($urandom));
               send_frame();
            end
            gaps_on = 1'b1;
         end
         first_frame = frames_sent;
         while (frames_sent - first_frame < 6) send_short_frame();
      end

      drain_results();
      repeat (10) @(negedge clock);

      $display("Sent %0d frames in %0d bytes; %0d offers accepted, %0d rejected.",
               frames_sent, bytes_sent, accepted_count, frames_sent - accepted_count);
      $display("Covered the reset length, option records of every kind, short frames %s",
               "at low settings, and stalls on both sides.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
